[hdl/rbf_pkg.sv]
package rbf_pkg;

  // Default build of the exp table: samples over [0, EXP_ARG_LIMIT).
  localparam int EXP_TABLE_DEPTH_DEF = 256;
  localparam int EXP_ARG_LIMIT_DEF   = 16;

  // Shape register after reset: 2.0 in unsigned Q8.8.
  localparam logic [15:0] SHAPE_RESET = 16'd512;

  // Rounding offsets for Q.32 and Q.16 right shifts (round half up).
  localparam logic [31:0] RND_Q32 = 32'h8000_0000;
  localparam logic [15:0] RND_Q16 = 16'h8000;

  // Magnitude ceiling applied to gradient and off-diagonal terms: 2^40.
  localparam logic [40:0] MAG_CEIL = 41'h100_0000_0000;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } rbf_in_t;

  typedef struct packed {
    logic        [16:0] phi;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic signed [31:0] hess_xx;
    logic signed [31:0] hess_xy;
    logic signed [31:0] hess_xz;
    logic signed [31:0] hess_yy;
    logic signed [31:0] hess_yz;
    logic signed [31:0] hess_zz;
  } rbf_out_t;

  // Clamp a magnitude to the 2^40 ceiling.
  function automatic logic [40:0] clamp_mag(input logic [51:0] v);
    return (v > 52'(MAG_CEIL)) ? MAG_CEIL : v[40:0];
  endfunction

  // Saturate a signed value to the 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [42:0] v);
    logic [31:0] r;
    if (v > 43'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -43'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/rbf_stream_if.sv]
interface rbf_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/gaussian_rbf_value_gradient_hessian.sv]
// Gaussian radial basis kernel in 3D: value, gradient and Hessian.
//
// Channels (valid/ready, a beat moves on a clock edge with both high):
//   query    : sink, one beat = center and point, signed Q16.16 each.
//   result   : source, one beat = phi (Q1.16) plus gradient and the six
//              distinct Hessian entries, signed Q16.16, saturated.
//   shape_wr : sink, one beat writes the 16-bit shape s (unsigned Q8.8).
//              Always ready; write it only while no query is in flight.
// Throughput: one query per cycle while result is not stalled. Thirteen
// register stages, each about one 32x32 multiplier or one wide add deep;
// the critical stages are the partial products of the 64-bit Q.32 multiplies.
// Stall: every stage holds while the stage after it is full and stalled, so
// bubbles close up and query stays ready until the whole pipe is full behind
// a stalled result.
// Reset (rst, synchronous): drop every beat in flight, set shape to 2.0.
module gaussian_rbf_value_gradient_hessian #(
  parameter int EXP_TABLE_DEPTH = rbf_pkg::EXP_TABLE_DEPTH_DEF,
  parameter int EXP_ARG_LIMIT   = rbf_pkg::EXP_ARG_LIMIT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  rbf_stream_if.sink   query,
  rbf_stream_if.source result,
  rbf_stream_if.sink   shape_wr
);
  import rbf_pkg::*;

  localparam int NS = 13;

  // x is known below EXP_ARG_LIMIT * 2^16 wherever its bits matter.
  localparam int XW  = $clog2(EXP_ARG_LIMIT) + 16;
  // Divide x by the limit: multiply by a rounded-up reciprocal.
  localparam int KX  = XW + 6;
  localparam longint unsigned MX = ((64'd1 << KX) + EXP_ARG_LIMIT - 1) / EXP_ARG_LIMIT;
  localparam int MXW = $clog2(MX + 1);
  // Remainder times depth over the limit, same trick.
  localparam int RW  = $clog2(EXP_ARG_LIMIT);
  localparam int IW  = $clog2(EXP_TABLE_DEPTH);
  localparam int PW  = IW + 16;
  localparam int K2  = RW + IW + 6;
  localparam longint unsigned MR = ((64'd1 << K2) + EXP_ARG_LIMIT - 1) / EXP_ARG_LIMIT;
  localparam longint unsigned CR = MR * EXP_TABLE_DEPTH;
  localparam int CRW = $clog2(CR + 1);
  localparam logic [64:0] LIMQ = 65'(EXP_ARG_LIMIT) << 16;

  // Pair order of the Hessian slots: xx, xy, xz, yy, yz, zz.
  localparam logic [1:0] PAIR_I [6] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_J [6] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  // Table entry: sample k (17 bits) and its drop to sample k+1 (17 bits).
  typedef logic [EXP_TABLE_DEPTH-1:0][33:0] tab_t;

  function automatic tab_t build_tab();
    longint unsigned t;
    longint unsigned e;
    longint unsigned v;
    longint unsigned tk;
    longint unsigned tn;
    longint          sum;
    tab_t            tab;
    t   = 64'd1 << 32;
    sum = 64'sd1 << 32;
    for (int n = 1; n <= 40; n++) begin
      t = (t * EXP_ARG_LIMIT) / 64'(EXP_TABLE_DEPTH * n);
      if (n[0]) begin
        sum = sum - longint'(t);
      end else begin
        sum = sum + longint'(t);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    e = longint'(sum);
    if (e > 64'hFFFF_FFFF) begin
      e = 64'hFFFF_FFFF;
    end
    v = 64'd1 << 32;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      tk = (v + 64'd32768) >> 16;
      v  = (v * e + 64'd2147483648) >> 32;
      tn = (v + 64'd32768) >> 16;
      tab[k] = {17'(tk), 17'((tk >= tn) ? (tk - tn) : 64'd0)};
    end
    return tab;
  endfunction

  localparam tab_t EXP_TAB = build_tab();

  typedef struct packed {
    logic [2:0]            neg;   // sign of each offset
    logic [2:0][31:0]      mag;   // |p_i|
    logic [2:0][63:0]      sq;    // p_i^2
    logic [2:0][63:0]      a;     // s^2 |p_i|, Q.32
    logic [63:0]           psq;   // |p|^2, saturated
    logic [5:0][3:0][63:0] pp;    // partial products of a_i * a_j
    logic [5:0][63:0]      t;     // round(a_i a_j), Q.32
    logic [63:0]           mh;
    logic [63:0]           ml;
    logic                  near;  // x below the table limit
    logic [XW-1:0]         x;
    logic [15:0]           qx;
    logic [RW-1:0]         rx;
    logic [PW-1:0]         pos;   // table index and 16 fraction bits
    logic [16:0]           t0;
    logic [32:0]           prod;
    logic [16:0]           phi;
    logic [2:0][49:0]      gh;
    logic [2:0][49:0]      gl;
    logic [5:0][50:0]      oh;
    logic [5:0][50:0]      ol;
    logic [48:0]           dg;
    logic [2:0][40:0]      gm;
    logic [5:0][40:0]      om;
    logic [33:0]           dgr;
    rbf_out_t              res;
  } pipe_t;

  logic [15:0]     shape;
  logic [31:0]     s2;
  logic [NS-1:0]   vld;
  logic [NS-1:0]   adv;
  pipe_t           pl      [NS];
  pipe_t           pl_next [NS];
  logic [2:0][31:0] pt;
  logic [2:0][31:0] ct;

  assign pt = {query.data.point_z, query.data.point_y, query.data.point_x};
  assign ct = {query.data.center_z, query.data.center_y, query.data.center_x};

  // Shape register and its square; the square is registered from shape and
  // trails it, which the idle-only write rule covers.
  assign shape_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape <= SHAPE_RESET;
    end else if (shape_wr.valid) begin
      shape <= shape_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    s2 <= 32'(shape) * 32'(shape);
  end

  // Advance chain: a stage loads when it is empty or its successor moves.
  always_comb begin
    adv[NS-1] = !vld[NS-1] || result.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign query.ready  = adv[0];
  assign result.valid = vld[NS-1];
  assign result.data  = pl[NS-1].res;

  always_comb begin
    logic [32:0]        pd;
    logic [65:0]        sum3;
    logic [97:0]        tsum;
    logic [64:0]        x65;
    logic [XW+MXW-1:0]  qx_prod;
    logic [RW+CRW-1:0]  qr_prod;
    logic [IW-1:0]      qr;
    logic [33:0]        ent;
    logic [17:0]        b2;
    logic [18:0]        b4;
    logic signed [42:0] sv;
    logic [5:0][31:0]   hres;
    logic [2:0][31:0]   gres;

    pl_next[0] = '0;
    for (int k = 1; k < NS; k++) begin
      pl_next[k] = pl[k-1];
    end

    // Stage 0: offset p = point - center, split into sign and magnitude.
    for (int i = 0; i < 3; i++) begin
      pd = {pt[i][31], pt[i]} - {ct[i][31], ct[i]};
      pl_next[0].neg[i] = pd[32];
      pl_next[0].mag[i] = pd[32] ? 32'(-pd) : pd[31:0];
    end

    // Stage 1: squares and scaled magnitudes.
    for (int i = 0; i < 3; i++) begin
      pl_next[1].sq[i] = {32'b0, pl[0].mag[i]} * {32'b0, pl[0].mag[i]};
      pl_next[1].a[i]  = {32'b0, s2} * {32'b0, pl[0].mag[i]};
    end

    // Stage 2: |p|^2 with saturation; partial products of a_i * a_j.
    sum3 = 66'(pl[1].sq[0]) + 66'(pl[1].sq[1]) + 66'(pl[1].sq[2]);
    pl_next[2].psq = (|sum3[65:64]) ? '1 : sum3[63:0];
    for (int s = 0; s < 6; s++) begin
      pl_next[2].pp[s][0] = {32'b0, pl[1].a[PAIR_I[s]][63:32]} *
                            {32'b0, pl[1].a[PAIR_J[s]][63:32]};
      pl_next[2].pp[s][1] = {32'b0, pl[1].a[PAIR_I[s]][63:32]} *
                            {32'b0, pl[1].a[PAIR_J[s]][31:0]};
      pl_next[2].pp[s][2] = {32'b0, pl[1].a[PAIR_I[s]][31:0]} *
                            {32'b0, pl[1].a[PAIR_J[s]][63:32]};
      pl_next[2].pp[s][3] = {32'b0, pl[1].a[PAIR_I[s]][31:0]} *
                            {32'b0, pl[1].a[PAIR_J[s]][31:0]};
    end

    // Stage 3: s^2 |p|^2 halves; sum the a_i a_j partials, round, saturate.
    pl_next[3].mh = {32'b0, s2} * {32'b0, pl[2].psq[63:32]};
    pl_next[3].ml = {32'b0, s2} * {32'b0, pl[2].psq[31:0]};
    for (int s = 0; s < 6; s++) begin
      tsum = {2'b0, pl[2].pp[s][0], 32'b0} + 98'(pl[2].pp[s][1]) +
             98'(pl[2].pp[s][2]) +
             98'((65'(pl[2].pp[s][3]) + 65'(RND_Q32)) >> 32);
      pl_next[3].t[s] = (|tsum[97:64]) ? '1 : tsum[63:0];
    end

    // Stage 4: x = round(s^2 |p|^2) in Q16.16, and the range check.
    x65 = 65'(pl[3].mh) + ((65'(pl[3].ml) + 65'(RND_Q32)) >> 32);
    pl_next[4].near = (x65 < LIMQ);
    pl_next[4].x    = XW'(x65);

    // Stage 5: quotient of x by the limit.
    qx_prod = (XW+MXW)'(pl[4].x) * (XW+MXW)'(MX);
    pl_next[5].qx = 16'(qx_prod >> KX);

    // Stage 6: remainder of that division.
    pl_next[6].rx = RW'(pl[5].x - XW'(32'(pl[5].qx) * EXP_ARG_LIMIT));

    // Stage 7: table position x * depth / limit.
    qr_prod = (RW+CRW)'(pl[6].rx) * (RW+CRW)'(CR);
    qr      = IW'(qr_prod >> K2);
    pl_next[7].pos = PW'(32'(pl[6].qx) * EXP_TABLE_DEPTH) + PW'(qr);

    // Stage 8: table read and interpolation product.
    ent = EXP_TAB[pl[7].pos[PW-1:16]];
    pl_next[8].t0   = ent[33:17];
    pl_next[8].prod = 33'(ent[16:0]) * 33'(pl[7].pos[15:0]);

    // Stage 9: phi, zero past the table.
    pl_next[9].phi = pl[8].near ?
                     (pl[8].t0 - 17'((pl[8].prod + 33'(RND_Q16)) >> 16)) : 17'd0;

    // Stage 10: products with 2 phi, 4 phi and s^2 phi.
    b2 = {pl[9].phi, 1'b0};
    b4 = {pl[9].phi, 2'b0};
    for (int i = 0; i < 3; i++) begin
      pl_next[10].gh[i] = 50'(pl[9].a[i][63:32]) * 50'(b2);
      pl_next[10].gl[i] = 50'(pl[9].a[i][31:0]) * 50'(b2);
    end
    for (int s = 0; s < 6; s++) begin
      pl_next[10].oh[s] = 51'(pl[9].t[s][63:32]) * 51'(b4);
      pl_next[10].ol[s] = 51'(pl[9].t[s][31:0]) * 51'(b4);
    end
    pl_next[10].dg = 49'(s2) * 49'(pl[9].phi);

    // Stage 11: rounded magnitudes, clamped.
    for (int i = 0; i < 3; i++) begin
      pl_next[11].gm[i] = clamp_mag(52'(pl[10].gh[i]) +
                                    52'((51'(pl[10].gl[i]) + 51'(RND_Q32)) >> 32));
    end
    for (int s = 0; s < 6; s++) begin
      pl_next[11].om[s] = clamp_mag(52'(pl[10].oh[s]) +
                                    52'((52'(pl[10].ol[s]) + 52'(RND_Q32)) >> 32));
    end
    pl_next[11].dgr = 34'((50'({pl[10].dg, 1'b0}) + 50'(RND_Q16)) >> 16);

    // Stage 12: apply signs, subtract the diagonal term, saturate.
    for (int i = 0; i < 3; i++) begin
      sv = pl[11].neg[i] ? 43'(pl[11].gm[i]) : -43'(pl[11].gm[i]);
      gres[i] = sat32(sv);
    end
    for (int s = 0; s < 6; s++) begin
      sv = (pl[11].neg[PAIR_I[s]] != pl[11].neg[PAIR_J[s]]) ?
           -43'(pl[11].om[s]) : 43'(pl[11].om[s]);
      if (PAIR_I[s] == PAIR_J[s]) begin
        sv = sv - 43'(pl[11].dgr);
      end
      hres[s] = sat32(sv);
    end
    pl_next[12].res.phi     = pl[11].phi;
    pl_next[12].res.grad_x  = gres[0];
    pl_next[12].res.grad_y  = gres[1];
    pl_next[12].res.grad_z  = gres[2];
    pl_next[12].res.hess_xx = hres[0];
    pl_next[12].res.hess_xy = hres[1];
    pl_next[12].res.hess_xz = hres[2];
    pl_next[12].res.hess_yy = hres[3];
    pl_next[12].res.hess_yz = hres[4];
    pl_next[12].res.hess_zz = hres[5];
  end

  // Valid bits travel with the data; drop them all on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= query.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Payload holds while its stage is stalled.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (adv[k]) begin
        pl[k] <= pl_next[k];
      end
    end
  end

`ifndef SYNTHESIS
  a_rst_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    !query.ready |-> vld[NS-1] && !result.ready)
    else $error("query stalled without output backpressure");

  a_far_zero: assert property (@(posedge clk) disable iff (rst)
    vld[9] && !pl[9].near |-> pl[9].phi == 17'd0)
    else $error("phi nonzero past the table range");

  a_phi_max: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.data.phi <= 17'd65536)
    else $error("phi above 1.0");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    vld[7] && pl[7].near |-> 32'(pl[7].pos[PW-1:16]) < EXP_TABLE_DEPTH)
    else $error("exp table index out of range");
`endif

endmodule
